// ===== design/dbwc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbwc_pkg: shared types and constants of the dust blob window classifier
// Register indexes, configuration and result words, accumulator word and
// the extent clamp used by the window counters and the sequencer.
// ----------------------------------------------------------------------------
package dbwc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BAND_LOW   = 3'd0,
        REG_BAND_HIGH  = 3'd1,
        REG_MAX_DOTS   = 3'd2,
        REG_MAX_EXTENT = 3'd3,
        REG_MAX_SPREAD = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  band_low;
        logic [7:0]  band_high;
        logic [15:0] max_dots;
        logic [6:0]  max_extent;
        logic [11:0] max_spread;
    } cfg_t;

    typedef struct packed {
        logic [15:0] dots;
        logic [23:0] sum;
        logic [31:0] sqsum;
        logic [7:0]  min_col;
        logic [7:0]  max_col;
        logic [7:0]  min_row;
        logic [7:0]  max_row;
    } acc_t;

    typedef struct packed {
        logic        is_dust;
        logic [15:0] dot_count;
        logic [7:0]  extent;
        logic        too_long;
        logic        too_many;
        logic        too_spread;
    } res_t;

    function automatic logic [6:0] eff_extent(input logic [6:0] m, input logic [6:0] lim);
        logic [6:0] e;
        e = m;
        if (e == 7'd0)
        begin
            e = 7'd1;
        end
        if (e > lim)
        begin
            e = lim;
        end
        return e;
    endfunction

endpackage
`default_nettype wire

// ===== design/dbwc_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbwc_mul: shared multiplier
// One unsigned multiply per cycle with a registered product, loaded on enable.
// ----------------------------------------------------------------------------
module dbwc_mul (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [dbwc_pkg::MUL_A_W-1:0] a,
    input  wire logic [dbwc_pkg::MUL_B_W-1:0] b,
    output logic      [dbwc_pkg::PROD_W-1:0]  prod
);

    logic [dbwc_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= {{dbwc_pkg::MUL_B_W{1'b0}}, a} * {{dbwc_pkg::MUL_A_W{1'b0}}, b};
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// ===== design/dbwc_accum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbwc_accum: window counters and pixel accumulators
// Tracks raster position, dot count, dot bounding box and background sums.
// ----------------------------------------------------------------------------
module dbwc_accum (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire logic [7:0]     pixel,
    input  wire logic [7:0]     side,
    input  wire dbwc_pkg::cfg_t cfg,
    input  wire logic           clr,
    output logic                last_pixel,
    output dbwc_pkg::acc_t      acc
);

    logic [7:0]     col_reg, col_next;
    logic [7:0]     row_reg, row_next;
    dbwc_pkg::acc_t acc_reg, acc_next;
    logic           is_dot;
    logic           last_col;
    logic [15:0]    sq;

    assign is_dot     = (cfg.band_low <= pixel) && (pixel <= cfg.band_high);
    assign last_col   = ({1'b0, col_reg} + 9'd1) >= {1'b0, side};
    assign last_pixel = last_col && (({1'b0, row_reg} + 9'd1) >= {1'b0, side});
    assign sq         = {8'h00, pixel} * {8'h00, pixel};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        acc_next = acc_reg;
        if (clr)
        begin
            col_next         = 8'd0;
            row_next         = 8'd0;
            acc_next.dots    = 16'd0;
            acc_next.sum     = 24'd0;
            acc_next.sqsum   = 32'd0;
            acc_next.min_col = 8'hFF;
            acc_next.max_col = 8'd0;
            acc_next.min_row = 8'hFF;
            acc_next.max_row = 8'd0;
        end
        else if (fire)
        begin
            if (is_dot)
            begin
                if (col_reg < acc_reg.min_col)
                begin
                    acc_next.min_col = col_reg;
                end
                if (col_reg > acc_reg.max_col)
                begin
                    acc_next.max_col = col_reg;
                end
                if (row_reg < acc_reg.min_row)
                begin
                    acc_next.min_row = row_reg;
                end
                if (row_reg > acc_reg.max_row)
                begin
                    acc_next.max_row = row_reg;
                end
                acc_next.dots = acc_reg.dots + 16'd1;
            end
            else
            begin
                acc_next.sum   = acc_reg.sum + {16'h0000, pixel};
                acc_next.sqsum = acc_reg.sqsum + {16'h0000, sq};
            end
            if (!last_col)
            begin
                col_next = col_reg + 8'd1;
            end
            else
            begin
                col_next = 8'd0;
                if (!last_pixel)
                begin
                    row_next = row_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= 8'd0;
            row_reg         <= 8'd0;
            acc_reg.dots    <= 16'd0;
            acc_reg.sum     <= 24'd0;
            acc_reg.sqsum   <= 32'd0;
            acc_reg.min_col <= 8'hFF;
            acc_reg.max_col <= 8'd0;
            acc_reg.min_row <= 8'hFF;
            acc_reg.max_row <= 8'd0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

// ===== design/dbwc_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbwc_seq: end-of-window sequencer
// Runs the spread test through the shared multiplier, forms the verdict and
// holds the result word until the receiver takes it.
// ----------------------------------------------------------------------------
module dbwc_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire dbwc_pkg::acc_t acc,
    input  wire dbwc_pkg::cfg_t cfg,
    input  wire logic [6:0]     ext_lim,
    input  wire logic [7:0]     side,
    input  wire logic           out_ready,
    output logic                busy,
    output logic                clr,
    output logic                out_valid,
    output dbwc_pkg::res_t      res
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_TOT  = 9'b000000010,
        S_N    = 9'b000000100,
        S_NQ   = 9'b000001000,
        S_NN   = 9'b000010000,
        S_MS   = 9'b000100000,
        S_LIM  = 9'b001000000,
        S_CMP  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t                       state_reg, state_next;
    logic                         mul_en;
    logic [dbwc_pkg::MUL_A_W-1:0] mul_a;
    logic [dbwc_pkg::MUL_B_W-1:0] mul_b;
    logic [dbwc_pkg::PROD_W-1:0]  prod;
    logic [15:0]                  n_reg;
    logic [47:0]                  s2_reg;
    logic [47:0]                  nq_reg;
    logic [31:0]                  nn_reg;
    logic [47:0]                  var_reg;
    logic                         spread_reg;
    logic                         out_valid_reg, out_valid_next;
    dbwc_pkg::res_t               res_reg, res_next;
    logic [15:0]                  total;
    logic [7:0]                   dc, dr, ext;
    logic                         load;

    dbwc_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign total = prod[15:0];
    assign dc    = (acc.max_col >= acc.min_col) ? acc.max_col - acc.min_col : 8'd0;
    assign dr    = (acc.max_row >= acc.min_row) ? acc.max_row - acc.min_row : 8'd0;
    assign ext   = (acc.dots == 16'd0) ? 8'd0 : ((dc > dr) ? dc : dr);
    assign load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_TOT;
                end
            end
            S_TOT:
            begin
                mul_en     = 1'b1;
                mul_a      = {24'h0, side};
                mul_b      = {16'h0, side};
                state_next = S_N;
            end
            S_N:
            begin
                mul_en     = 1'b1;
                mul_a      = {8'h00, acc.sum};
                mul_b      = acc.sum;
                state_next = S_NQ;
            end
            S_NQ:
            begin
                mul_en     = 1'b1;
                mul_a      = acc.sqsum;
                mul_b      = {8'h00, n_reg};
                state_next = S_NN;
            end
            S_NN:
            begin
                mul_en     = 1'b1;
                mul_a      = {16'h0000, n_reg};
                mul_b      = {8'h00, n_reg};
                state_next = S_MS;
            end
            S_MS:
            begin
                mul_en     = 1'b1;
                mul_a      = {20'h0, cfg.max_spread};
                mul_b      = {12'h0, cfg.max_spread};
                state_next = S_LIM;
            end
            S_LIM:
            begin
                mul_en     = 1'b1;
                mul_a      = nn_reg;
                mul_b      = prod[23:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_N)
        begin
            n_reg <= (total > acc.dots) ? total - acc.dots : 16'd0;
        end
        if (state_reg == S_NQ)
        begin
            s2_reg <= prod[47:0];
        end
        if (state_reg == S_NN)
        begin
            nq_reg <= prod[47:0];
        end
        if (state_reg == S_MS)
        begin
            nn_reg <= prod[31:0];
        end
        if (state_reg == S_LIM)
        begin
            var_reg <= (nq_reg > s2_reg) ? nq_reg - s2_reg : 48'd0;
        end
        if (state_reg == S_CMP)
        begin
            spread_reg <= (n_reg != 16'd0) && ({var_reg, 8'h00} > prod);
        end
    end

    always_comb
    begin
        res_next            = res_reg;
        res_next.too_long   = ext > {1'b0, ext_lim};
        res_next.too_many   = acc.dots > cfg.max_dots;
        res_next.too_spread = spread_reg;
        res_next.dot_count  = acc.dots;
        res_next.extent     = ext;
        res_next.is_dust    = !res_next.too_long && !res_next.too_many && !spread_reg;
        if (!load)
        begin
            res_next = res_reg;
        end
    end

    always_comb
    begin
        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign clr       = load;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

// ===== design/dust_blob_window_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dust_blob_window_classifier: dust verdict over a square pixel window
// Counts in-band dots, tracks their bounding box and tests the background
// spread of each window of pixels given in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   pixel channel  : one 8-bit pixel per word, valid/ready. A side of the
//                    window is W = 3 * E, E = max_extent clamped to
//                    1..MAX_EXTENT_LIMIT.
//   result channel : one word per window, valid/ready, held in an output
//                    register until taken.
//   cfg channel    : cfg_index/cfg_data writes, always ready; an index past
//                    the register list is dropped.
//   Throughput     : one pixel per cycle inside a window. The last pixel of
//                    a window starts a pass through the shared multiplier,
//                    during which pixel_ready is low.
//   Sequence       : S_TOT, S_N, S_NQ, S_NN, S_MS, S_LIM and S_CMP, then
//                    S_DONE loads the result register and raises result_valid.
//   Stall          : the next window is taken while a result waits; at that
//                    window's end the sequencer holds until the output
//                    register is free.
//   Reset          : clears counters, accumulators, configuration and
//                    sequencer state to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module dust_blob_window_classifier #(
    parameter int MAX_EXTENT_LIMIT = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               pixel_valid,
    output logic                                    pixel_ready,
    input  wire logic [7:0]                         pixel,
    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output logic                                    is_dust,
    output logic [15:0]                             dot_count,
    output logic [7:0]                              extent,
    output logic                                    too_long,
    output logic                                    too_many,
    output logic                                    too_spread,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dbwc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dbwc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [6:0] EXT_LIMIT = 7'(MAX_EXTENT_LIMIT);

    dbwc_pkg::cfg_t cfg_reg, cfg_next;
    dbwc_pkg::acc_t acc;
    dbwc_pkg::res_t res;
    logic [6:0]     ext_lim;
    logic [7:0]     side;
    logic           fire;
    logic           last_pixel;
    logic           busy;
    logic           clr;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                dbwc_pkg::REG_BAND_LOW:   cfg_next.band_low   = cfg_data[7:0];
                dbwc_pkg::REG_BAND_HIGH:  cfg_next.band_high  = cfg_data[7:0];
                dbwc_pkg::REG_MAX_DOTS:   cfg_next.max_dots   = cfg_data;
                dbwc_pkg::REG_MAX_EXTENT: cfg_next.max_extent = cfg_data[6:0];
                dbwc_pkg::REG_MAX_SPREAD: cfg_next.max_spread = cfg_data[11:0];
                default:                  cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_low   <= 8'd0;
            cfg_reg.band_high  <= 8'd255;
            cfg_reg.max_dots   <= 16'd100;
            cfg_reg.max_extent <= 7'd8;
            cfg_reg.max_spread <= 12'd160;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign ext_lim     = dbwc_pkg::eff_extent(cfg_reg.max_extent, EXT_LIMIT);
    assign side        = {ext_lim, 1'b0} + {1'b0, ext_lim};
    assign pixel_ready = !busy;
    assign fire        = pixel_valid && pixel_ready;

    dbwc_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .pixel      (pixel),
        .side       (side),
        .cfg        (cfg_reg),
        .clr        (clr),
        .last_pixel (last_pixel),
        .acc        (acc)
    );

    dbwc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (fire && last_pixel),
        .acc       (acc),
        .cfg       (cfg_reg),
        .ext_lim   (ext_lim),
        .side      (side),
        .out_ready (result_ready),
        .busy      (busy),
        .clr       (clr),
        .out_valid (result_valid),
        .res       (res)
    );

    assign is_dust    = res.is_dust;
    assign dot_count  = res.dot_count;
    assign extent     = res.extent;
    assign too_long   = res.too_long;
    assign too_many   = res.too_many;
    assign too_spread = res.too_spread;

endmodule
`default_nettype wire

// ===== design/dbwc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbwc_checker: port-level checks of the dust blob window classifier
// Watches the result word against its own flags and the pixel handshake.
// ----------------------------------------------------------------------------
module dbwc_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pixel_ready,
    input  wire logic                            result_valid,
    input  wire logic                            result_ready,
    input  wire logic                            is_dust,
    input  wire logic [15:0]                     dot_count,
    input  wire logic [7:0]                      extent,
    input  wire logic                            too_long,
    input  wire logic                            too_many,
    input  wire logic                            too_spread
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(dot_count)
            && $stable(extent) && $stable(is_dust) && $stable(too_spread))
        else $error("result word changed while stalled");

    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> is_dust == (!too_long && !too_many && !too_spread))
        else $error("verdict disagrees with fail flags");

    a_no_dots: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && dot_count == 16'd0 |-> extent == 8'd0 && !too_long && !too_many)
        else $error("empty window reports extent or count failure");

    a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(pixel_ready))
        else $error("result appeared without end-of-window pass");

endmodule

bind dust_blob_window_classifier dbwc_checker u_dbwc_checker (.*);
`default_nettype wire
